FILE: hdl/spm_pkg.sv
package spm_pkg;

    // field widths
    localparam int CMD_W    = 1;
    localparam int IDX_W    = 3;
    localparam int SPEED_W  = 24;
    localparam int VAL_W    = 32;
    localparam int PCT_W    = 8;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // speed after override stays below 2^26 (24-bit request times 255 / 100)
    localparam int S_W      = 26;

    // shared multiplier
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;

    // x / 100 == (x * magic) >> 37 for every 32-bit x
    localparam logic [MUL_W-1:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int DIV100_SHIFT = 37;

    // 16.16 slope
    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

    localparam int MAX_POINTS_DEF = 8;

    localparam logic [PCT_W-1:0] PCT_RESET   = 8'd100;
    localparam logic [CNT_W-1:0] POINTS_RESET = 4'd0;
    localparam logic             ZOD_RESET   = 1'b1;

    localparam logic [VAL_W-1:0] VAL_ALL_ONES = '1;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_MAP  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_PERCENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ON_DISABLE  = 2'd2;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [VAL_W-1:0]   offset;
        logic [VAL_W-1:0]   slope;
    } t_point;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [VAL_W-1:0] device_value;
        logic [VAL_W-1:0] applied_speed;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PCT,
        ST_MUL_DIV,
        ST_CHECK,
        ST_FIRST,
        ST_WALK,
        ST_INTERP,
        ST_SUM,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/piecewise_linear_speed_map.sv
// load transaction: taken when the sequencer is idle, a load may follow in the very next cycle
// map transaction: request scaled by the override percent, then divided by 100; zeroed
//   or empty-table results go straight to the output, else the walk reads breakpoints in
//   order and settles on one or, between two, interpolates with a multiply and a saturating sum
// one map in flight, the next transaction is taken the cycle after the result is registered;
//   each map runs on the breakpoint ram walk and shared 32x32 multiplier, reset clears all control
module piecewise_linear_speed_map #(
    parameter int MAX_POINTS = spm_pkg::MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [spm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [spm_pkg::IDX_W-1:0]      i_point_index,
    input  logic [spm_pkg::SPEED_W-1:0]    i_point_speed,
    input  logic [spm_pkg::VAL_W-1:0]      i_point_offset,
    input  logic [spm_pkg::VAL_W-1:0]      i_point_slope,
    input  logic                           i_spindle_disable,
    input  logic [spm_pkg::SPEED_W-1:0]    i_request_speed,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [spm_pkg::VAL_W-1:0]      o_device_value,
    output logic [spm_pkg::VAL_W-1:0]      o_applied_speed
);
    import spm_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // configuration registers
    logic [CNT_W-1:0] r_points_in_use, n_points_in_use;
    logic [PCT_W-1:0] r_override_percent, n_override_percent;
    logic             r_zero_on_disable, n_zero_on_disable;

    // output register
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             w_accept;
    logic             w_load;
    logic             w_start;
    logic             w_busy;
    logic [AW-1:0]    w_rd_addr;
    t_point           w_rd_data;
    t_point           w_wr_data;
    t_mul_req         w_mul_req;
    logic [PROD_W-1:0] w_mul_prod;
    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;

    // the sequencer only takes a transaction when it sits idle
    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;

    // loads go straight into the table; indexes past the table depth are dropped
    assign w_load  = w_accept && (i_cmd == CMD_LOAD) && (32'(i_point_index) < MAX_POINTS);
    assign w_start = w_accept && (i_cmd == CMD_MAP);

    assign w_wr_data.speed  = i_point_speed;
    assign w_wr_data.offset = i_point_offset;
    assign w_wr_data.slope  = i_point_slope;

    // config decode
    always_comb begin
        n_points_in_use    = r_points_in_use;
        n_override_percent = r_override_percent;
        n_zero_on_disable  = r_zero_on_disable;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POINTS_IN_USE:    n_points_in_use    = i_cfg_data[CNT_W-1:0];
                CFG_OVERRIDE_PERCENT: n_override_percent = i_cfg_data[PCT_W-1:0];
                CFG_ZERO_ON_DISABLE:  n_zero_on_disable  = i_cfg_data[0];
                default: begin
                    // unknown register, write ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use    <= POINTS_RESET;
            r_override_percent <= PCT_RESET;
            r_zero_on_disable  <= ZOD_RESET;
        end else begin
            r_points_in_use    <= n_points_in_use;
            r_override_percent <= n_override_percent;
            r_zero_on_disable  <= n_zero_on_disable;
        end
    end

    // breakpoint table: speed, offset and slope side by side in one ram word
    spm_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(i_point_index)),
        .i_wdata (w_wr_data),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // shared multiplier: override percent, divide by 100, then interpolation
    spm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_mul_prod)
    );

    spm_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (w_start),
        .i_spindle_disable  (i_spindle_disable),
        .i_request_speed    (i_request_speed),
        .i_points_in_use    (r_points_in_use),
        .i_override_percent (r_override_percent),
        .i_zero_on_disable  (r_zero_on_disable),
        .o_rd_addr          (w_rd_addr),
        .i_rd_data          (w_rd_data),
        .o_mul_req          (w_mul_req),
        .i_mul_prod         (w_mul_prod),
        .o_busy             (w_busy),
        .o_res_valid        (w_res_valid),
        .i_res_ready        (w_res_ready),
        .o_res              (w_res)
    );

    // output register parts the sequencer from the downstream stall, so loads and
    // the start of the next map carry on while a result waits to be taken
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid     = r_out_valid;
    assign o_device_value  = r_out.device_value;
    assign o_applied_speed = r_out.applied_speed;

endmodule

FILE: hdl/spm_ram.sv
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/spm_mul.sv
module spm_mul (
    input  logic                     i_clk,
    input  spm_pkg::t_mul_req        i_req,
    output logic [spm_pkg::PROD_W-1:0] o_prod
);
    import spm_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = r_prod;
        if (i_req.en) begin
            n_prod = PROD_W'(i_req.a) * PROD_W'(i_req.b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/spm_ctrl.sv
module spm_ctrl #(
    parameter int MAX_POINTS = spm_pkg::MAX_POINTS_DEF,
    parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // map transaction start
    input  logic                         i_start,
    input  logic                         i_spindle_disable,
    input  logic [spm_pkg::SPEED_W-1:0]  i_request_speed,
    // configuration
    input  logic [spm_pkg::CNT_W-1:0]    i_points_in_use,
    input  logic [spm_pkg::PCT_W-1:0]    i_override_percent,
    input  logic                         i_zero_on_disable,
    // table read
    output logic [AW-1:0]                o_rd_addr,
    input  spm_pkg::t_point              i_rd_data,
    // shared multiplier
    output spm_pkg::t_mul_req            o_mul_req,
    input  logic [spm_pkg::PROD_W-1:0]   i_mul_prod,
    // status and result
    output logic                         o_busy,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output spm_pkg::t_result             o_res
);
    import spm_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    t_state             r_state, n_state;
    logic               r_dis, n_dis;
    logic [SPEED_W-1:0] r_req, n_req;
    logic [S_W-1:0]     r_s, n_s;
    logic               r_zero, n_zero;
    logic [VAL_W-1:0]   r_val, n_val;
    t_point             r_cur, n_cur;
    logic [AW-1:0]      r_j, n_j;

    logic [CW-1:0]      w_n;
    logic               w_last;
    logic [SUM_W-1:0]   w_sum;

    // count clamped to the table depth
    always_comb begin
        if (32'(i_points_in_use) > MAX_POINTS) begin
            w_n = CW'(MAX_POINTS);
        end else begin
            w_n = CW'(i_points_in_use);
        end
    end

    assign w_last = (CW'(r_j) + CW'(1)) == w_n;
    assign w_sum  = SUM_W'(r_cur.offset) + SUM_W'(i_mul_prod[PROD_W-1:FRAC_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dis  <= n_dis;
        r_req  <= n_req;
        r_s    <= n_s;
        r_zero <= n_zero;
        r_val  <= n_val;
        r_cur  <= n_cur;
        r_j    <= n_j;
    end

    always_comb begin
        n_state   = r_state;
        n_dis     = r_dis;
        n_req     = r_req;
        n_s       = r_s;
        n_zero    = r_zero;
        n_val     = r_val;
        n_cur     = r_cur;
        n_j       = r_j;
        o_rd_addr = r_j;
        o_mul_req = '0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_dis   = i_spindle_disable;
                    n_req   = i_request_speed;
                    n_state = ST_MUL_PCT;
                end
            end
            ST_MUL_PCT: begin
                o_mul_req.en = 1'b1;
                o_mul_req.a  = MUL_W'(r_req);
                o_mul_req.b  = MUL_W'(i_override_percent);
                n_state      = ST_MUL_DIV;
            end
            ST_MUL_DIV: begin
                // divide by 100 through the reciprocal
                o_mul_req.en = 1'b1;
                o_mul_req.a  = i_mul_prod[MUL_W-1:0];
                o_mul_req.b  = DIV100_MAGIC;
                n_state      = ST_MUL_DIV == r_state ? ST_CHECK : ST_MUL_DIV;
            end
            ST_CHECK: begin
                n_s    = i_mul_prod[DIV100_SHIFT+S_W-1:DIV100_SHIFT];
                n_zero = r_dis && i_zero_on_disable;
                o_rd_addr = '0;
                if ((r_dis && i_zero_on_disable) || (w_n == '0)) begin
                    n_val   = '0;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                n_cur = i_rd_data;
                if ((r_s < S_W'(i_rd_data.speed)) || (r_s == '0)) begin
                    n_val   = i_rd_data.offset;
                    n_state = ST_OUT;
                end else if (w_n == CW'(1)) begin
                    n_val   = (i_rd_data.offset == VAL_ALL_ONES) ? VAL_W'(r_s)
                                                                : i_rd_data.offset;
                    n_state = ST_OUT;
                end else begin
                    n_j       = AW'(1);
                    o_rd_addr = AW'(1);
                    n_state   = ST_WALK;
                end
            end
            ST_WALK: begin
                // i_rd_data holds point r_j, r_cur holds point r_j - 1
                if (r_s < S_W'(i_rd_data.speed)) begin
                    n_state = ST_INTERP;
                end else if (w_last) begin
                    n_val   = (i_rd_data.offset == VAL_ALL_ONES) ? VAL_W'(r_s)
                                                                : i_rd_data.offset;
                    n_state = ST_OUT;
                end else begin
                    n_cur     = i_rd_data;
                    n_j       = r_j + AW'(1);
                    o_rd_addr = r_j + AW'(1);
                end
            end
            ST_INTERP: begin
                if (r_cur.offset == VAL_ALL_ONES) begin
                    n_val   = VAL_W'(r_s);
                    n_state = ST_OUT;
                end else begin
                    o_mul_req.en = 1'b1;
                    o_mul_req.a  = MUL_W'(r_s) - MUL_W'(r_cur.speed);
                    o_mul_req.b  = r_cur.slope;
                    n_state      = ST_SUM;
                end
            end
            ST_SUM: begin
                // saturate at 32 bits
                if (|w_sum[SUM_W-1:VAL_W]) begin
                    n_val = VAL_ALL_ONES;
                end else begin
                    n_val = w_sum[VAL_W-1:0];
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != ST_IDLE;
    assign o_res.device_value  = r_val;
    assign o_res.applied_speed = r_zero ? '0 : VAL_W'(r_s);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

// bench for the piecewise-linear speed map
// a shadow copy of the breakpoints and the three config registers predicts every map
// transaction; results are checked in order against a queue of expected drive values
module tb_top;
    import spm_pkg::*;

    localparam int NUM_POINTS = MAX_POINTS_DEF;
    // wait covers the worst map, plus margin for a load still in progress
    localparam int SETTLE_CYCLES = NUM_POINTS + 12;
    // the one index of the write port that decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int MAX_REPORTS = 60;
    // slowest legal run is roughly 2 ms, so this leaves plenty of room
    localparam int RUN_LIMIT_NS = 10_000_000;

    // clock, reset and every block input start at a known value
    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  i_in_valid        = 1'b0;
    logic [CMD_W-1:0]      i_cmd             = CMD_LOAD;
    logic [IDX_W-1:0]      i_point_index     = '0;
    logic [SPEED_W-1:0]    i_point_speed     = '0;
    logic [VAL_W-1:0]      i_point_offset    = '0;
    logic [VAL_W-1:0]      i_point_slope     = '0;
    logic                  i_spindle_disable = 1'b0;
    logic [SPEED_W-1:0]    i_request_speed   = '0;
    logic                  i_out_stall       = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [VAL_W-1:0]      o_device_value;
    logic [VAL_W-1:0]      o_applied_speed;

    // shadow breakpoint store and register copies
    logic [SPEED_W-1:0] knot_rpm  [NUM_POINTS];
    logic [VAL_W-1:0]   knot_base [NUM_POINTS];
    logic [VAL_W-1:0]   knot_gain [NUM_POINTS];
    logic [CNT_W-1:0]   sh_points = POINTS_RESET;
    logic [PCT_W-1:0]   sh_pct    = PCT_RESET;
    logic               sh_zod    = ZOD_RESET;

    // drive values still owed by the block, oldest first
    t_result drive_due [$];

    int unsigned n_fail    = 0;
    int unsigned n_maps    = 0;
    int unsigned n_loads   = 0;
    int unsigned n_results = 0;
    int unsigned n_cfg     = 0;

    // idling controls: random gaps on the sender and receiver side
    bit tx_jitter = 1'b0;
    bit rx_jitter = 1'b0;
    // long receiver hold, requested by bumping the tag
    int unsigned hold_len  = 0;
    int unsigned hold_tag  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_run    = 0;

    // override and count settings visited by the sweep, extremes included
    int unsigned sweep_pts [7] = '{0, 1, 2, 7, 8, 9, 15};
    int unsigned sweep_pct [7] = '{0, 255, 1, 100, 254, 99, 37};

    piecewise_linear_speed_map #(
        .MAX_POINTS(NUM_POINTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_cmd(i_cmd),
        .i_point_index(i_point_index),
        .i_point_speed(i_point_speed),
        .i_point_offset(i_point_offset),
        .i_point_slope(i_point_slope),
        .i_spindle_disable(i_spindle_disable),
        .i_request_speed(i_request_speed),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_device_value(o_device_value),
        .o_applied_speed(o_applied_speed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap lengths from three bands: mostly the shortest, now and then a long one
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // expected drive value and applied speed for one map transaction
    function automatic t_result expected_drive(input logic dis, input logic [SPEED_W-1:0] req);
        logic [63:0] rpm;
        logic [63:0] acc;
        int unsigned used;
        int unsigned seg;
        t_result res;
        rpm = (64'(req) * 64'(sh_pct)) / 64'd100;
        res = '0;
        // disabled spindle with the flag set: both outputs forced to zero
        if (dis && sh_zod) return res;
        res.applied_speed = rpm[VAL_W-1:0];
        // counts beyond the table size behave as a full table
        used = (sh_points > NUM_POINTS) ? NUM_POINTS : sh_points;
        if (used == 0) begin
            acc = '0;
        end else if (rpm < knot_rpm[0] || rpm == 0) begin
            acc = knot_base[0];
        end else begin
            // first segment whose upper breakpoint lies above the speed
            seg = 0;
            while (seg + 1 < used && rpm >= knot_rpm[seg + 1]) seg++;
            if (knot_base[seg] == VAL_ALL_ONES) begin
                // unset offset passes the speed straight through
                acc = rpm;
            end else begin
                acc = knot_base[seg];
                // the last breakpoint holds its offset, others interpolate
                if (seg + 1 < used) begin
                    acc += ((rpm - knot_rpm[seg]) * knot_gain[seg]) >> FRAC_BITS;
                    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                end
            end
        end
        res.device_value = acc[VAL_W-1:0];
        return res;
    endfunction

    // request that lands on, next to or between breakpoints after the override
    function automatic logic [SPEED_W-1:0] aim_request();
        logic [63:0] goal;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        goal = knot_rpm[$urandom_range(0, NUM_POINTS - 1)];
        if (pick < 3) return '0;
        if (pick < 20) return SPEED_W'($urandom);
        if (pick >= 45 && pick < 65) begin
            goal = goal + $urandom_range(0, 6) - 3;
        end else if (pick >= 65) begin
            goal = goal + $urandom_range(0, 1 << 16);
        end
        if (sh_pct == 0) return SPEED_W'($urandom);
        // round the inverse override down or up so both sides of a breakpoint are hit
        goal = (goal * 100 + ($urandom_range(0, 1) == 1 ? sh_pct - 1 : 0)) / sh_pct;
        if (goal > 64'hFF_FFFF) goal = 64'hFF_FFFF;
        return goal[SPEED_W-1:0];
    endfunction

    // offer one transaction and hold it until taken; valid stays high unless a gap follows
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [SPEED_W-1:0] rpm, input logic [VAL_W-1:0] base,
                             input logic [VAL_W-1:0] gain, input logic dis,
                             input logic [SPEED_W-1:0] req);
        int unsigned gap;
        i_in_valid        <= 1'b1;
        i_cmd             <= cmd;
        i_point_index     <= idx;
        i_point_speed     <= rpm;
        i_point_offset    <= base;
        i_point_slope     <= gain;
        i_spindle_disable <= dis;
        i_request_speed   <= req;
        do @(posedge i_clk); while (o_in_stall);
        // transaction taken at this edge: update the shadow or queue the result
        if (cmd == CMD_LOAD) begin
            if (idx < NUM_POINTS) begin
                knot_rpm[idx]  = rpm;
                knot_base[idx] = base;
                knot_gain[idx] = gain;
            end
            n_loads++;
        end else begin
            drive_due.insert(drive_due.size(), expected_drive(dis, req));
            n_maps++;
        end
        if (tx_jitter && $urandom_range(0, 1) == 1) gap = pick_idle();
        else gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // unused fields of each kind of transaction carry random bits
    task automatic send_map(input logic dis, input logic [SPEED_W-1:0] req);
        send_item(CMD_MAP, IDX_W'($urandom), SPEED_W'($urandom), $urandom, $urandom, dis, req);
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic [SPEED_W-1:0] rpm,
                             input logic [VAL_W-1:0] base, input logic [VAL_W-1:0] gain);
        send_item(CMD_LOAD, idx, rpm, base, gain, 1'($urandom), SPEED_W'($urandom));
    endtask

    // sender pauses until the block owes nothing; always lets at least one edge pass
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (drive_due.size() != 0);
    endtask

    // idle point for register writes: drained, and any trailing load finished
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_POINTS_IN_USE:    sh_points = data[CNT_W-1:0];
            CFG_OVERRIDE_PERCENT: sh_pct    = data;
            CFG_ZERO_ON_DISABLE:  sh_zod    = data[0];
            default: ;
        endcase
        n_cfg++;
    endtask

    // all three registers; unused upper data bits are sometimes random
    task automatic apply_setting(input logic [CNT_W-1:0] pts, input logic [PCT_W-1:0] pct,
                                 input logic zod);
        logic [CFG_DATA_W-1:0] data;
        data = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
        data[CNT_W-1:0] = pts;
        write_reg(CFG_POINTS_IN_USE, data);
        write_reg(CFG_OVERRIDE_PERCENT, pct);
        data = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
        data[0] = zod;
        write_reg(CFG_ZERO_ON_DISABLE, data);
        // a write to the spare index must leave everything alone
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // a sorted breakpoint set with random offsets and slopes
    task automatic load_ramp();
        logic [63:0] rpm;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] gain;
        int unsigned k;
        rpm = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 1 << 20));
        for (k = 0; k < NUM_POINTS; k++) begin
            base = ($urandom_range(0, 9) == 0) ? VAL_ALL_ONES : VAL_W'($urandom);
            case ($urandom_range(0, 3))
                0: gain = $urandom_range(0, 1 << 16);
                1: gain = $urandom_range(0, 1 << 22);
                2: gain = $urandom;
                default: gain = '0;
            endcase
            send_load(IDX_W'(k), rpm[SPEED_W-1:0], base, gain);
            if ($urandom_range(0, 4) == 0) rpm = rpm + $urandom_range(0, 1 << 21);
            else rpm = rpm + $urandom_range(1, 1 << 16);
            if (rpm > 64'hFF_FFFF) rpm = 64'hFF_FFFF;
        end
    endtask

    // mostly aimed maps, a few stray loads that unsort the breakpoints
    task automatic run_burst(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 6) begin
                send_load(IDX_W'($urandom), SPEED_W'($urandom), $urandom, $urandom);
            end else begin
                send_map($urandom_range(0, 3) == 0, aim_request());
            end
        end
    endtask

    // reset values: empty table, 100 percent, zero-on-disable set
    task automatic test_reset_defaults();
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        send_map(1'b1, 24'hFF_FFFF);
        send_map(1'b0, 24'h00_0000);
        send_map(1'b0, 24'hFF_FFFF);
        settle();
    endtask

    // hand-built breakpoints that hit every branch of the segment walk
    task automatic test_table_walk();
        send_load(3'd0, 24'd1000,     32'd100,      32'h0001_0000);
        send_load(3'd1, 24'd2000,     32'd1100,     32'h0002_8000);
        send_load(3'd2, 24'd5000,     VAL_ALL_ONES, 32'h0000_1234);
        send_load(3'd3, 24'd8000,     32'd20000,    32'h0000_0001);
        send_load(3'd4, 24'd12000,    32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_load(3'd5, 24'd20000,    32'd0,        32'd0);
        send_load(3'd6, 24'd1000000,  32'd42,       32'h8000_0000);
        send_load(3'd7, 24'hFF_FFFF,  32'hDEAD_BEEF, 32'h0100_0000);
        settle();
        apply_setting(4'd8, 8'd100, 1'b0);
        write_reg(CFG_SPARE, 8'hFF);
        send_map(1'b0, 24'd0);        // zero speed gives the first offset
        send_map(1'b0, 24'd500);      // below the first breakpoint
        send_map(1'b0, 24'd1000);     // exactly on the first breakpoint
        send_map(1'b0, 24'd1500);     // plain interpolation
        send_map(1'b0, 24'd3000);     // fractional slope
        send_map(1'b0, 24'd6000);     // unset offset, speed passed through
        send_map(1'b0, 24'd9000);     // slope too small to move the value
        send_map(1'b0, 24'd15000);    // sum saturates
        send_map(1'b0, 24'hFF_FFFF);  // last breakpoint holds its offset
        send_map(1'b1, 24'd1500);     // disabled but the flag is clear
        settle();
        apply_setting(4'd15, 8'd100, 1'b0);   // count above table size
        send_map(1'b0, 24'hFF_FFFF);
        settle();
        apply_setting(4'd8, 8'd255, 1'b0);    // largest override, beyond last point
        send_map(1'b0, 24'hFF_FFFF);
        settle();
        apply_setting(4'd8, 8'd0, 1'b0);      // zero override
        send_map(1'b0, 24'hFF_FFFF);
        settle();
        apply_setting(4'd1, 8'd100, 1'b1);    // single breakpoint
        send_map(1'b0, 24'd5000);
        send_map(1'b1, 24'd5000);
        settle();
    endtask

    // fixed list of register settings, each with a short random burst
    task automatic test_config_sweep();
        int unsigned k;
        for (k = 0; k < 7; k++) begin
            settle();
            tx_jitter = k[0];
            rx_jitter = !k[0];
            apply_setting(CNT_W'(sweep_pts[k]), PCT_W'(sweep_pct[k]), k[1]);
            run_burst(25);
        end
    endtask

    // random register settings with fresh sorted breakpoints most of the time
    task automatic test_random_traffic();
        int unsigned ph;
        int unsigned r;
        logic [CNT_W-1:0] pts;
        logic [PCT_W-1:0] pct;
        for (ph = 0; ph < 18; ph++) begin
            settle();
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            if (r < 5) pts = 4'd8;
            else if (r < 8) pts = CNT_W'($urandom_range(1, 7));
            else if (r < 9) pts = 4'd0;
            else pts = CNT_W'($urandom_range(9, 15));
            r = $urandom_range(0, 9);
            if (r < 4) pct = 8'd100;
            else if (r < 8) pct = PCT_W'($urandom);
            else pct = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            apply_setting(pts, pct, 1'($urandom));
            if ($urandom_range(0, 9) < 7) load_ramp();
            run_burst(60);
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering maps
    task automatic test_output_hold();
        settle();
        apply_setting(4'd8, 8'd100, 1'b0);
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        hold_len = 300;
        hold_tag++;
        run_burst(40);
        settle();
    endtask

    // sender stops between bursts until every result is back
    task automatic test_sender_pause();
        int unsigned k;
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        for (k = 0; k < 4; k++) begin
            run_burst(10);
            drain_results();
        end
    endtask

    // receiver: long hold on request, otherwise random stall runs or none at all
    always @(posedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            rx_run = 0;
            i_out_stall <= 1'b1;
        end else if (!rx_jitter) begin
            i_out_stall <= 1'b0;
        end else if (rx_run != 0) begin
            rx_run--;
        end else if ($urandom_range(0, 1) == 1) begin
            i_out_stall <= 1'b1;
            rx_run = pick_idle() - 1;
        end else begin
            i_out_stall <= 1'b0;
            rx_run = $urandom_range(0, 7);
        end
    end

    // every accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (drive_due.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("%0t: unexpected result, device_value %h applied_speed %h",
                             $time, o_device_value, o_applied_speed);
            end else begin
                want = drive_due.pop_front();
                if (o_device_value !== want.device_value) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: device_value mismatch, expected %h, actual %h",
                                 $time, want.device_value, o_device_value);
                end
                if (o_applied_speed !== want.applied_speed) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: applied_speed mismatch, expected %h, actual %h",
                                 $time, want.applied_speed, o_applied_speed);
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_table_walk();
        test_config_sweep();
        test_random_traffic();
        test_output_hold();
        test_sender_pause();
        settle();
        $display("run covered %0d map and %0d load transactions, %0d results, %0d register writes",
                 n_maps, n_loads, n_results, n_cfg);
        $display("including segment walks, saturation, pass-through, override extremes and hold-off");
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #RUN_LIMIT_NS;
        $display("run timed out with %0d results outstanding", drive_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/spm_pkg.sv
hdl/spm_ram.sv
hdl/spm_mul.sv
hdl/spm_ctrl.sv
hdl/piecewise_linear_speed_map.sv
test/tb_top.sv
